[design/cdas_pkg.sv]
package cdas_pkg;

    // Field widths
    localparam int YEAR_W = 16;
    localparam int MON_W  = 4;
    localparam int DAY_FW = 5;
    localparam int HR_W   = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;
    localparam int TIME_W = 6;

    // Duration day width default and iteration width margin
    localparam int DUR_DAY_BITS_DEF = 10;
    localparam int DAY_MARGIN       = 2;

    // Result transaction layout, lowest bit first
    localparam int OUT_YEAR_LSB = 0;
    localparam int OUT_MON_LSB  = OUT_YEAR_LSB + YEAR_W;
    localparam int OUT_DAY_LSB  = OUT_MON_LSB + MON_W;
    localparam int OUT_HR_LSB   = OUT_DAY_LSB + DAY_FW;
    localparam int OUT_MIN_LSB  = OUT_HR_LSB + HR_W;
    localparam int OUT_SEC_LSB  = OUT_MIN_LSB + MIN_W;
    localparam int OUT_BITS     = OUT_SEC_LSB + SEC_W;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // Time radices
    localparam logic [TIME_W-1:0] SEC_PER_MIN = 6'd60;
    localparam logic [TIME_W-1:0] MIN_PER_HR  = 6'd60;
    localparam logic [TIME_W-1:0] HR_PER_DAY  = 6'd24;

    // Months
    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_APR = 4'd4;
    localparam logic [MON_W-1:0] MON_JUN = 4'd6;
    localparam logic [MON_W-1:0] MON_SEP = 4'd9;
    localparam logic [MON_W-1:0] MON_NOV = 4'd11;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    localparam logic [DAY_FW-1:0] DAYS_31 = 5'd31;
    localparam logic [DAY_FW-1:0] DAYS_30 = 5'd30;
    localparam logic [DAY_FW-1:0] DAYS_29 = 5'd29;
    localparam logic [DAY_FW-1:0] DAYS_28 = 5'd28;

    // Year / 100 by reciprocal: floor(y * RECIP_100 / 2^RECIP_SHIFT) is exact for 16-bit y
    localparam int RECIP_100   = 167773;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 24;
    localparam int CENT_QW     = 10;
    localparam int YMOD_W      = 7;
    localparam int CENTURY     = 100;

    // Shared adder control
    typedef struct packed {
        logic sub;   // 1: a - b - cin, 0: a + b + cin
        logic wrap;  // fold result into [0, lim)
        logic cin;   // carry or borrow in
    } alu_ctl_t;

    // Year tracker commands
    typedef struct packed {
        logic load;
        logic inc;
        logic dec;
    } yr_cmd_t;

    // Length of a month, months outside 1..12 read as 31
    function automatic logic [DAY_FW-1:0] month_days(input logic [MON_W-1:0] mon,
                                                     input logic leap);
        logic [DAY_FW-1:0] d;
        d = DAYS_31;
        if (mon == MON_FEB) begin
            d = leap ? DAYS_29 : DAYS_28;
        end else if (mon == MON_APR || mon == MON_JUN || mon == MON_SEP || mon == MON_NOV) begin
            d = DAYS_30;
        end
        return d;
    endfunction

endpackage

[design/cdas_alu.sv]
module cdas_alu
    import cdas_pkg::*;
#(
    parameter int W = DUR_DAY_BITS_DEF + DAY_MARGIN
) (
    input  logic [W-1:0]      a,
    input  logic [W-1:0]      b,
    input  alu_ctl_t          ctl,
    input  logic [TIME_W-1:0] lim,
    output logic [W-1:0]      res,
    output logic              flag
);

    logic [W:0] raw;
    logic [W:0] lim_x;
    logic [W:0] adj;

    // Add or subtract with carry, then optional fold by the radix
    always_comb begin
        lim_x = (W+1)'(lim);
        if (ctl.sub) begin
            raw  = {1'b0, a} - {1'b0, b} - (W+1)'(ctl.cin);
            flag = raw[W];
            adj  = raw + lim_x;
            res  = (flag && ctl.wrap) ? adj[W-1:0] : raw[W-1:0];
        end else begin
            raw  = {1'b0, a} + {1'b0, b} + (W+1)'(ctl.cin);
            flag = ctl.wrap && (raw >= lim_x);
            adj  = raw - lim_x;
            res  = flag ? adj[W-1:0] : raw[W-1:0];
        end
    end

endmodule

[design/cdas_year.sv]
module cdas_year
    import cdas_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  yr_cmd_t           cmd,
    input  logic [YEAR_W-1:0] year_in,
    output logic [YEAR_W-1:0] year,
    output logic              leap
);

    localparam logic [YEAR_W-1:0]  YEAR_TOP = '1;
    localparam logic [YMOD_W-1:0]  YMOD_TOP = YMOD_W'((2**YEAR_W - 1) % CENTURY);
    localparam logic [1:0]         CENT_TOP = 2'(((2**YEAR_W - 1) / CENTURY) % 4);
    localparam logic [YMOD_W-1:0]  YMOD_MAX = YMOD_W'(CENTURY - 1);

    logic [YEAR_W-1:0]  yr_reg, yr_next;
    logic [YMOD_W-1:0]  ymod_reg, ymod_next;   // year mod 100
    logic [1:0]         cent_reg, cent_next;   // (year / 100) mod 4
    logic [CENT_QW-1:0] q_reg, q_next;
    logic               fix_reg;
    logic [YEAR_W+RECIP_W-1:0] prod;
    logic [YEAR_W-1:0]  rem;

    assign prod = (YEAR_W+RECIP_W)'(year_in) * (YEAR_W+RECIP_W)'(RECIP_100);
    assign rem  = yr_reg - YEAR_W'(q_reg * CENTURY);

    // Leap: divisible by 4 and not by 100, or by 400
    assign leap = (yr_reg[1:0] == 2'd0) && ((ymod_reg != '0) || (cent_reg == 2'd0));
    assign year = yr_reg;

    // Load registers the year and quotient first; fix_reg then fills in the remainder and century
    always_comb begin
        yr_next   = yr_reg;
        ymod_next = ymod_reg;
        cent_next = cent_reg;
        q_next    = q_reg;
        if (cmd.load) begin
            yr_next = year_in;
            q_next  = prod[RECIP_SHIFT +: CENT_QW];
        end else if (fix_reg) begin
            ymod_next = rem[YMOD_W-1:0];
            cent_next = q_reg[1:0];
        end else if (cmd.inc) begin
            if (yr_reg == YEAR_TOP) begin
                yr_next   = '0;
                ymod_next = '0;
                cent_next = '0;
            end else begin
                yr_next = yr_reg + 1'b1;
                if (ymod_reg == YMOD_MAX) begin
                    ymod_next = '0;
                    cent_next = cent_reg + 2'd1;
                end else begin
                    ymod_next = ymod_reg + 1'b1;
                end
            end
        end else if (cmd.dec) begin
            if (yr_reg == '0) begin
                yr_next   = YEAR_TOP;
                ymod_next = YMOD_TOP;
                cent_next = CENT_TOP;
            end else begin
                yr_next = yr_reg - 1'b1;
                if (ymod_reg == '0) begin
                    ymod_next = YMOD_MAX;
                    cent_next = cent_reg - 2'd1;
                end else begin
                    ymod_next = ymod_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fix_reg <= 1'b0;
        end else begin
            fix_reg <= cmd.load;
        end
    end

    always_ff @(posedge aclk) begin
        yr_reg   <= yr_next;
        ymod_reg <= ymod_next;
        cent_reg <= cent_next;
        q_reg    <= q_next;
    end

endmodule

[design/calendar_datetime_add_subtract.sv]
// Channel  Dir  Handshake         Payload (lowest bit first)
// s_       in   s_tvalid/tready   tdata: date y/m/d/h/m/s, dur days/h/m/s; tuser: subtract
// m_       out  m_tvalid/tready   tdata: year, month, day, hours, minutes, seconds
//
// The time a transaction takes grows with the number of months crossed; the month walk
// runs through the single shared adder.
// s_tready is high only between transactions; the next one is taken while a result waits.
// Reset (aresetn, synchronous, active low) clears the sequencer and the output valid.
// m_tready low holds the result register; the block finishes its work and then waits.
module calendar_datetime_add_subtract
    import cdas_pkg::*;
#(
    parameter int DUR_DAY_BITS = DUR_DAY_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // date_year, date_month, date_day, date_hours, date_minutes, date_seconds,
    // dur_days, dur_hours, dur_minutes, dur_seconds, zero fill
    input  logic [((59 + DUR_DAY_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // req_type
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // res_year, res_month, res_day, res_hours, res_minutes, res_seconds, zero fill
    output logic [OUT_TDATA_W-1:0]  m_tdata
);

    localparam int DAY_W = DUR_DAY_BITS + DAY_MARGIN;

    // Input transaction layout
    localparam int I_YEAR = 0;
    localparam int I_MON  = I_YEAR + YEAR_W;
    localparam int I_DAY  = I_MON + MON_W;
    localparam int I_HR   = I_DAY + DAY_FW;
    localparam int I_MIN  = I_HR + HR_W;
    localparam int I_SEC  = I_MIN + MIN_W;
    localparam int I_DD   = I_SEC + SEC_W;
    localparam int I_UHR  = I_DD + DUR_DAY_BITS;
    localparam int I_UMIN = I_UHR + HR_W;
    localparam int I_USEC = I_UMIN + MIN_W;

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_DS    = 18'h00002,
        S_DM    = 18'h00004,
        S_DH    = 18'h00008,
        S_US    = 18'h00010,
        S_UM    = 18'h00020,
        S_UH    = 18'h00040,
        S_TS    = 18'h00080,
        S_TM    = 18'h00100,
        S_TH    = 18'h00200,
        S_DDAY  = 18'h00400,
        S_ADAY  = 18'h00800,
        S_FWD   = 18'h01000,
        S_ADD   = 18'h02000,
        S_BINIT = 18'h04000,
        S_BLOOP = 18'h08000,
        S_BFIN  = 18'h10000,
        S_DONE  = 18'h20000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic               sub_reg, sub_next;
    logic [MON_W-1:0]   mon_reg, mon_next;
    logic [DAY_W-1:0]   day_reg, day_next;
    logic [DAY_W-1:0]   dd_reg, dd_next;        // duration days, then days left to borrow
    logic [HR_W-1:0]    hr_reg, hr_next;
    logic [MIN_W-1:0]   mi_reg, mi_next;
    logic [SEC_W-1:0]   se_reg, se_next;
    logic [HR_W-1:0]    uhr_reg, uhr_next;
    logic [MIN_W-1:0]   umi_reg, umi_next;
    logic [SEC_W-1:0]   use_reg, use_next;
    logic               cy_reg, cy_next;
    logic               ca_reg, ca_next;        // date time carry into day
    logic               cd_reg, cd_next;        // duration time carry into days
    logic               phase_reg, phase_next;  // forward walk: 0 normalize, 1 after add
    logic               fsel_reg, fsel_next;    // final borrow without any month step

    logic [DAY_W-1:0]   alu_a, alu_b, alu_res;
    alu_ctl_t           alu_ctl;
    logic [TIME_W-1:0]  alu_lim;
    logic               alu_flag;

    yr_cmd_t            ycmd;
    logic [YEAR_W-1:0]  year;
    logic               leap;

    logic [MON_W-1:0]   in_mon, mon_prev;
    logic [DAY_FW-1:0]  in_day;
    logic [DAY_W-1:0]   md_cur, md_prev;
    logic               accept;

    cdas_alu #(.W(DAY_W)) u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .ctl  (alu_ctl),
        .lim  (alu_lim),
        .res  (alu_res),
        .flag (alu_flag)
    );

    cdas_year u_year (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ycmd),
        .year_in (s_tdata[I_YEAR +: YEAR_W]),
        .year    (year),
        .leap    (leap)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Month and day clamp on intake
    assign in_mon = (s_tdata[I_MON +: MON_W] == '0)    ? MON_JAN :
                    (s_tdata[I_MON +: MON_W] > MON_DEC) ? MON_DEC : s_tdata[I_MON +: MON_W];
    assign in_day = (s_tdata[I_DAY +: DAY_FW] == '0) ? DAY_FW'(1) : s_tdata[I_DAY +: DAY_FW];

    // Month lengths; stepping back from January gives December, 31 days in any year
    assign mon_prev = (mon_reg == MON_JAN) ? MON_DEC : mon_reg - 4'd1;
    assign md_cur   = DAY_W'(month_days(mon_reg, leap));
    assign md_prev  = DAY_W'(month_days(mon_prev, leap));

    // Sequencer and shared adder operand select
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        sub_next      = sub_reg;
        mon_next      = mon_reg;
        day_next      = day_reg;
        dd_next       = dd_reg;
        hr_next       = hr_reg;
        mi_next       = mi_reg;
        se_next       = se_reg;
        uhr_next      = uhr_reg;
        umi_next      = umi_reg;
        use_next      = use_reg;
        cy_next       = cy_reg;
        ca_next       = ca_reg;
        cd_next       = cd_reg;
        phase_next    = phase_reg;
        fsel_next     = fsel_reg;
        alu_a         = '0;
        alu_b         = '0;
        alu_ctl       = '{sub: 1'b0, wrap: 1'b0, cin: 1'b0};
        alu_lim       = SEC_PER_MIN;
        ycmd          = '{load: 1'b0, inc: 1'b0, dec: 1'b0};

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    ycmd.load  = 1'b1;
                    sub_next   = s_tuser;
                    mon_next   = in_mon;
                    day_next   = DAY_W'(in_day);
                    hr_next    = s_tdata[I_HR +: HR_W];
                    mi_next    = s_tdata[I_MIN +: MIN_W];
                    se_next    = s_tdata[I_SEC +: SEC_W];
                    dd_next    = DAY_W'(s_tdata[I_DD +: DUR_DAY_BITS]);
                    uhr_next   = s_tdata[I_UHR +: HR_W];
                    umi_next   = s_tdata[I_UMIN +: MIN_W];
                    use_next   = s_tdata[I_USEC +: SEC_W];
                    state_next = S_DS;
                end
            end
            // Normalize date time of day
            S_DS: begin
                alu_a        = DAY_W'(se_reg);
                alu_ctl.wrap = 1'b1;
                se_next      = alu_res[SEC_W-1:0];
                cy_next      = alu_flag;
                state_next   = S_DM;
            end
            S_DM: begin
                alu_a        = DAY_W'(mi_reg);
                alu_ctl.wrap = 1'b1;
                alu_ctl.cin  = cy_reg;
                alu_lim      = MIN_PER_HR;
                mi_next      = alu_res[MIN_W-1:0];
                cy_next      = alu_flag;
                state_next   = S_DH;
            end
            S_DH: begin
                alu_a        = DAY_W'(hr_reg);
                alu_ctl.wrap = 1'b1;
                alu_ctl.cin  = cy_reg;
                alu_lim      = HR_PER_DAY;
                hr_next      = alu_res[HR_W-1:0];
                ca_next      = alu_flag;
                state_next   = S_US;
            end
            // Normalize duration time of day
            S_US: begin
                alu_a        = DAY_W'(use_reg);
                alu_ctl.wrap = 1'b1;
                use_next     = alu_res[SEC_W-1:0];
                cy_next      = alu_flag;
                state_next   = S_UM;
            end
            S_UM: begin
                alu_a        = DAY_W'(umi_reg);
                alu_ctl.wrap = 1'b1;
                alu_ctl.cin  = cy_reg;
                alu_lim      = MIN_PER_HR;
                umi_next     = alu_res[MIN_W-1:0];
                cy_next      = alu_flag;
                state_next   = S_UH;
            end
            S_UH: begin
                alu_a        = DAY_W'(uhr_reg);
                alu_ctl.wrap = 1'b1;
                alu_ctl.cin  = cy_reg;
                alu_lim      = HR_PER_DAY;
                uhr_next     = alu_res[HR_W-1:0];
                cd_next      = alu_flag;
                state_next   = S_TS;
            end
            // Time of day add or subtract, carry or borrow chain
            S_TS: begin
                alu_a        = DAY_W'(se_reg);
                alu_b        = DAY_W'(use_reg);
                alu_ctl.sub  = sub_reg;
                alu_ctl.wrap = 1'b1;
                se_next      = alu_res[SEC_W-1:0];
                cy_next      = alu_flag;
                state_next   = S_TM;
            end
            S_TM: begin
                alu_a        = DAY_W'(mi_reg);
                alu_b        = DAY_W'(umi_reg);
                alu_ctl.sub  = sub_reg;
                alu_ctl.wrap = 1'b1;
                alu_ctl.cin  = cy_reg;
                alu_lim      = MIN_PER_HR;
                mi_next      = alu_res[MIN_W-1:0];
                cy_next      = alu_flag;
                state_next   = S_TH;
            end
            S_TH: begin
                alu_a        = DAY_W'(hr_reg);
                alu_b        = DAY_W'(uhr_reg);
                alu_ctl.sub  = sub_reg;
                alu_ctl.wrap = 1'b1;
                alu_ctl.cin  = cy_reg;
                alu_lim      = HR_PER_DAY;
                hr_next      = alu_res[HR_W-1:0];
                cy_next      = alu_flag;
                state_next   = S_DDAY;
            end
            // Duration days take both its own carry and the time chain carry
            S_DDAY: begin
                alu_a       = dd_reg;
                alu_b       = DAY_W'(cd_reg);
                alu_ctl.cin = cy_reg;
                dd_next     = alu_res;
                state_next  = S_ADAY;
            end
            S_ADAY: begin
                alu_a       = day_reg;
                alu_ctl.cin = ca_reg;
                day_next    = alu_res;
                phase_next  = 1'b0;
                state_next  = S_FWD;
            end
            // Walk forward one month while the day exceeds the month length
            S_FWD: begin
                alu_a       = day_reg;
                alu_b       = md_cur;
                alu_ctl.sub = 1'b1;
                if (!alu_flag && (alu_res != '0)) begin
                    day_next = alu_res;
                    if (mon_reg == MON_DEC) begin
                        mon_next = MON_JAN;
                        ycmd.inc = 1'b1;
                    end else begin
                        mon_next = mon_reg + 4'd1;
                    end
                end else if (phase_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = sub_reg ? S_BINIT : S_ADD;
                end
            end
            S_ADD: begin
                alu_a      = day_reg;
                alu_b      = dd_reg;
                day_next   = alu_res;
                phase_next = 1'b1;
                state_next = S_FWD;
            end
            // Days still to borrow: duration days minus day of month
            S_BINIT: begin
                alu_a       = dd_reg;
                alu_b       = day_reg;
                alu_ctl.sub = 1'b1;
                if (alu_flag) begin
                    fsel_next  = 1'b1;
                    state_next = S_BFIN;
                end else begin
                    dd_next    = alu_res;
                    state_next = S_BLOOP;
                end
            end
            // Step back one month per cycle until the borrow fits
            S_BLOOP: begin
                alu_a       = dd_reg;
                alu_b       = md_prev;
                alu_ctl.sub = 1'b1;
                mon_next    = mon_prev;
                ycmd.dec    = (mon_reg == MON_JAN);
                if (alu_flag) begin
                    fsel_next  = 1'b0;
                    state_next = S_BFIN;
                end else begin
                    dd_next = alu_res;
                end
            end
            S_BFIN: begin
                alu_a       = fsel_reg ? day_reg : md_cur;
                alu_b       = dd_reg;
                alu_ctl.sub = 1'b1;
                day_next    = alu_res;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_TDATA_W'({se_reg, mi_reg, hr_reg,
                                                  day_reg[DAY_FW-1:0], mon_reg, year});
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        sub_reg     <= sub_next;
        mon_reg     <= mon_next;
        day_reg     <= day_next;
        dd_reg      <= dd_next;
        hr_reg      <= hr_next;
        mi_reg      <= mi_next;
        se_reg      <= se_next;
        uhr_reg     <= uhr_next;
        umi_reg     <= umi_next;
        use_reg     <= use_next;
        cy_reg      <= cy_next;
        ca_reg      <= ca_next;
        cd_reg      <= cd_next;
        phase_reg   <= phase_next;
        fsel_reg    <= fsel_next;
    end

endmodule

[design/cdas_chk.sv]
module cdas_chk
    import cdas_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // Result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Month of a result is in 1..12 and its day is nonzero
    a_date_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_MON_LSB +: MON_W] != '0)
                  && (m_tdata[OUT_MON_LSB +: MON_W] <= MON_DEC)
                  && (m_tdata[OUT_DAY_LSB +: DAY_FW] != '0))
        else $error("result date out of range");

    // Time of day of a result is normalized
    a_time_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_HR_LSB +: HR_W] < HR_W'(HR_PER_DAY))
                  && (m_tdata[OUT_MIN_LSB +: MIN_W] < MIN_PER_HR)
                  && (m_tdata[OUT_SEC_LSB +: SEC_W] < SEC_PER_MIN))
        else $error("result time out of range");

    // A transaction occupies the block: no intake on the next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken back to back");

    // Reset clears the result channel
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind calendar_datetime_add_subtract cdas_chk u_cdas_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import cdas_pkg::*;

    localparam int S_TDATA_W   = ((59 + DUR_DAY_BITS_DEF + 7) / 8) * 8;
    localparam int REQ_BITS    = 59 + DUR_DAY_BITS_DEF;
    localparam int DAY_SECONDS = 86400;
    localparam int RANDOM_ITEMS = 1650;
    localparam int HOLD_CYCLES  = 400;
    localparam int TIMEOUT_NS   = 10_000_000;

    // Receiver stall patterns
    typedef enum int {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_PERIODIC
    } sink_mode_t;

    // One input transaction; packed so it can be filled from raw random bits
    typedef struct packed {
        logic                        sub;
        logic [YEAR_W-1:0]           year;
        logic [MON_W-1:0]            month;
        logic [DAY_FW-1:0]           day;
        logic [HR_W-1:0]             hours;
        logic [MIN_W-1:0]            minutes;
        logic [SEC_W-1:0]            seconds;
        logic [DUR_DAY_BITS_DEF-1:0] dur_days;
        logic [HR_W-1:0]             dur_hours;
        logic [MIN_W-1:0]            dur_minutes;
        logic [SEC_W-1:0]            dur_seconds;
    } dt_req_t;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_FW-1:0] day;
        logic [HR_W-1:0]   hours;
        logic [MIN_W-1:0]  minutes;
        logic [SEC_W-1:0]  seconds;
    } dt_res_t;

    // Predicts shifted date-times and checks them against the result channel
    class datetime_ledger;
        dt_res_t expected_dates[$];
        int      fail_count;

        function new();
            fail_count = 0;
        endfunction

        static function bit leap_year(logic [YEAR_W-1:0] yr);
            int unsigned y;
            y = yr;
            return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        endfunction

        static function int unsigned month_length(int unsigned mon, logic [YEAR_W-1:0] yr);
            if (mon == MON_FEB) begin
                return leap_year(yr) ? DAYS_29 : DAYS_28;
            end else if (mon == MON_APR || mon == MON_JUN || mon == MON_SEP
                         || mon == MON_NOV) begin
                return DAYS_30;
            end
            return DAYS_31;
        endfunction

        // Push surplus days into the following months
        function void roll_days(inout int unsigned day, inout int unsigned mon,
                                inout logic [YEAR_W-1:0] yr);
            while (day > month_length(mon, yr)) begin
                day -= month_length(mon, yr);
                mon++;
                if (mon > MON_DEC) begin
                    mon = MON_JAN;
                    yr  = yr + 16'd1;
                end
            end
        endfunction

        function dt_res_t shift_datetime(dt_req_t r);
            logic [YEAR_W-1:0] yr;
            int unsigned       mon, day, a_tod, d_days, d_tod, tod;
            dt_res_t           o;
            yr     = r.year;
            mon    = r.month;
            day    = r.day;
            a_tod  = int'(r.hours) * 3600 + int'(r.minutes) * 60 + int'(r.seconds);
            d_days = r.dur_days;
            d_tod  = int'(r.dur_hours) * 3600 + int'(r.dur_minutes) * 60
                   + int'(r.dur_seconds);

            // out-of-range month and day are clamped
            if (mon == 0) mon = MON_JAN;
            if (mon > MON_DEC) mon = MON_DEC;
            if (day == 0) day = 1;

            // whole days hidden in the time fields
            day    += a_tod / DAY_SECONDS;
            a_tod   = a_tod % DAY_SECONDS;
            d_days += d_tod / DAY_SECONDS;
            d_tod   = d_tod % DAY_SECONDS;
            roll_days(day, mon, yr);

            if (!r.sub) begin
                tod = a_tod + d_tod;
                if (tod >= DAY_SECONDS) begin
                    tod -= DAY_SECONDS;
                    d_days++;
                end
                day += d_days;
                roll_days(day, mon, yr);
            end else begin
                if (a_tod < d_tod) begin
                    tod = a_tod + DAY_SECONDS - d_tod;
                    d_days++;
                end else begin
                    tod = a_tod - d_tod;
                end
                // borrow whole months until the day stays positive
                while (day <= d_days) begin
                    if (mon == MON_JAN) begin
                        mon = MON_DEC;
                        yr  = yr - 16'd1;
                    end else begin
                        mon--;
                    end
                    day += month_length(mon, yr);
                end
                day -= d_days;
            end

            o.year    = yr;
            o.month   = MON_W'(mon);
            o.day     = DAY_FW'(day);
            o.hours   = HR_W'(tod / 3600);
            o.minutes = MIN_W'((tod / 60) % 60);
            o.seconds = SEC_W'(tod % 60);
            return o;
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction

        function void note_request(dt_req_t r);
            expected_dates.push_back(shift_datetime(r));
        endfunction

        task flag_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            fail_count++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] d);
            dt_res_t want, got;
            got.year    = d[OUT_YEAR_LSB +: YEAR_W];
            got.month   = d[OUT_MON_LSB +: MON_W];
            got.day     = d[OUT_DAY_LSB +: DAY_FW];
            got.hours   = d[OUT_HR_LSB +: HR_W];
            got.minutes = d[OUT_MIN_LSB +: MIN_W];
            got.seconds = d[OUT_SEC_LSB +: SEC_W];
            if (expected_dates.size() == 0) begin
                flag_mismatch($sformatf("result %h with no transaction outstanding", d));
                return;
            end
            want = expected_dates.pop_front();
            if (got.year !== want.year)
                flag_mismatch($sformatf("year exp %0d got %0d", want.year, got.year));
            if (got.month !== want.month)
                flag_mismatch($sformatf("month exp %0d got %0d", want.month, got.month));
            if (got.day !== want.day)
                flag_mismatch($sformatf("day exp %0d got %0d", want.day, got.day));
            if (got.hours !== want.hours)
                flag_mismatch($sformatf("hours exp %0d got %0d", want.hours, got.hours));
            if (got.minutes !== want.minutes)
                flag_mismatch($sformatf("minutes exp %0d got %0d", want.minutes,
                                        got.minutes));
            if (got.seconds !== want.seconds)
                flag_mismatch($sformatf("seconds exp %0d got %0d", want.seconds,
                                        got.seconds));
        endtask
    endclass

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    datetime_ledger book;
    sink_mode_t     sink_mode = SINK_ALWAYS;
    bit             hold_req  = 1'b0;

    calendar_datetime_add_subtract dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [S_TDATA_W-1:0] pack_request(dt_req_t r);
        logic [S_TDATA_W-1:0] v;
        v = '0;
        v[REQ_BITS-1:0] = {r.dur_seconds, r.dur_minutes, r.dur_hours, r.dur_days,
                           r.seconds, r.minutes, r.hours, r.day, r.month, r.year};
        return v;
    endfunction

    function automatic dt_req_t make_request(int sub, int y, int mo, int d, int h, int mi,
                                             int s, int dd, int dh, int dmi, int ds);
        dt_req_t r;
        r.sub         = 1'(sub);
        r.year        = YEAR_W'(y);
        r.month       = MON_W'(mo);
        r.day         = DAY_FW'(d);
        r.hours       = HR_W'(h);
        r.minutes     = MIN_W'(mi);
        r.seconds     = SEC_W'(s);
        r.dur_days    = DUR_DAY_BITS_DEF'(dd);
        r.dur_hours   = HR_W'(dh);
        r.dur_minutes = MIN_W'(dmi);
        r.dur_seconds = SEC_W'(ds);
        return r;
    endfunction

    // Mostly well-formed dates, with a share of raw bit patterns
    function automatic dt_req_t random_request();
        dt_req_t     r;
        logic [95:0] raw;
        int          y, mo, d;
        if ($urandom_range(0, 99) < 12) begin
            raw = {$urandom, $urandom, $urandom};
            r = raw[REQ_BITS:0];
            return r;
        end
        case ($urandom_range(0, 3))
            0, 1: y = $urandom_range(0, 65535);
            2:    y = $urandom_range(1580, 2500);
            default: begin
                case ($urandom_range(0, 5))
                    0: y = 0;
                    1: y = 65535;
                    2: y = 1900;
                    3: y = 2000;
                    4: y = 2100;
                    default: y = 400 * $urandom_range(0, 163);
                endcase
            end
        endcase
        mo = $urandom_range(1, 12);
        d  = $urandom_range(1, datetime_ledger::month_length(mo, YEAR_W'(y)));
        r = make_request($urandom_range(0, 1), y, mo, d, $urandom_range(0, 23),
                         $urandom_range(0, 59), $urandom_range(0, 59), 0,
                         $urandom_range(0, 23), $urandom_range(0, 59),
                         $urandom_range(0, 59));
        case ($urandom_range(0, 9))
            6, 7:    r.dur_days = DUR_DAY_BITS_DEF'($urandom_range(0, 62));
            8:       r.dur_days = $urandom_range(0, 1) ? '1 : '0;
            9:       r.dur_days = DUR_DAY_BITS_DEF'(d - $urandom_range(0, 1));
            default: r.dur_days = DUR_DAY_BITS_DEF'($urandom_range(0, 1023));
        endcase
        return r;
    endfunction

    // Offer one transaction, starting and ending on a falling edge
    task automatic send_request(dt_req_t r);
        s_tvalid <= 1'b1;
        s_tuser  <= r.sub;
        s_tdata  <= pack_request(r);
        do @(posedge aclk); while (!s_tready);
        book.note_request(r);
        @(negedge aclk);
    endtask

    task automatic idle_sender(int cycles);
        logic [95:0] junk;
        if (cycles > 0) begin
            junk = {$urandom, $urandom, $urandom};
            s_tvalid <= 1'b0;
            s_tuser  <= junk[95];
            s_tdata  <= junk[S_TDATA_W-1:0];
            repeat (cycles) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (book.pending() != 0) @(negedge aclk);
    endtask

    // Result side: stall pattern, long hold-off on request, check on each transaction
    initial begin : result_sink
        int hold_left;
        int tick;
        hold_left = 0;
        tick = 0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (sink_mode)
                    SINK_RANDOM:   m_tready <= ($urandom_range(0, 9) < 7);
                    SINK_PERIODIC: m_tready <= ((tick % 7) < 3);
                    default:       m_tready <= 1'b1;
                endcase
            end
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
                book.check_result(m_tdata);
            end
        end
    end

    initial begin : stimulus
        dt_req_t directed[$];
        int      sent;
        int      burst;
        bit      held_once, held_twice, drained;
        book = new();

        // reset
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // directed: leap rules, year wrap, clamping, carries and borrows, field extremes
        directed.push_back(make_request(0, 2000, 2, 29, 23, 59, 59, 0, 0, 0, 0));
        directed.push_back(make_request(0, 65535, 12, 31, 23, 59, 59, 0, 0, 0, 1));
        directed.push_back(make_request(1, 0, 1, 1, 0, 0, 0, 0, 0, 0, 1));
        directed.push_back(make_request(0, 1900, 2, 28, 12, 0, 0, 1, 0, 0, 0));
        directed.push_back(make_request(0, 2000, 2, 28, 12, 0, 0, 1, 0, 0, 0));
        directed.push_back(make_request(0, 2004, 2, 28, 0, 0, 0, 1, 0, 0, 0));
        directed.push_back(make_request(1, 2100, 3, 1, 0, 0, 0, 1, 0, 0, 0));
        directed.push_back(make_request(1, 2400, 3, 1, 6, 30, 0, 1, 0, 0, 0));
        directed.push_back(make_request(1, 2024, 3, 15, 12, 0, 0, 1023, 23, 59, 59));
        directed.push_back(make_request(0, 65534, 12, 31, 23, 59, 59, 1023, 23, 59, 59));
        directed.push_back(make_request(0, 2023, 0, 15, 1, 2, 3, 10, 0, 0, 0));
        directed.push_back(make_request(1, 2023, 15, 15, 1, 2, 3, 10, 0, 0, 0));
        directed.push_back(make_request(0, 2023, 5, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(0, 2023, 2, 31, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(0, 2023, 6, 30, 31, 63, 63, 0, 0, 0, 0));
        directed.push_back(make_request(1, 2023, 6, 30, 0, 0, 0, 0, 31, 63, 63));
        directed.push_back(make_request(1, 2023, 7, 10, 1, 0, 0, 0, 2, 0, 0));
        directed.push_back(make_request(1, 2023, 7, 5, 12, 0, 0, 5, 0, 0, 0));
        directed.push_back(make_request(0, 2023, 12, 31, 12, 0, 0, 0, 12, 0, 0));
        directed.push_back(make_request(1, 2023, 8, 8, 8, 8, 8, 0, 0, 0, 0));
        directed.push_back(make_request(0, 0, 1, 31, 0, 0, 0, 1023, 0, 0, 0));
        directed.push_back(make_request(1, 65535, 3, 1, 0, 0, 0, 1023, 23, 59, 59));
        directed.push_back(make_request(0, 65535, 15, 31, 31, 63, 63, 1023, 31, 63, 63));
        directed.push_back(make_request(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        foreach (directed[i]) send_request(directed[i]);
        wait_drained();

        // random bursts; receiver pattern changes every few hundred transactions
        sent = 0;
        held_once = 1'b0;
        held_twice = 1'b0;
        drained = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            case ((sent / 250) % 3)
                0:       sink_mode = SINK_RANDOM;
                1:       sink_mode = SINK_PERIODIC;
                default: sink_mode = SINK_ALWAYS;
            endcase
            if (!held_once && sent >= 400) begin
                hold_req = 1'b1;
                held_once = 1'b1;
            end
            if (!held_twice && sent >= 1200) begin
                hold_req = 1'b1;
                held_twice = 1'b1;
            end
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                send_request(random_request());
                sent++;
            end
            if (!drained && sent >= 800) begin
                wait_drained();
                drained = 1'b1;
            end else if (sent >= 1000 && sent < 1150) begin
                // stretch with no sender gaps
            end else if ($urandom_range(0, 3) != 0) begin
                idle_sender($urandom_range(1, 20));
            end
        end
        s_tvalid <= 1'b0;

        // drain, then watch for stray results
        while (book.pending() != 0) @(negedge aclk);
        repeat (100) @(posedge aclk);
        if (book.fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
design/cdas_pkg.sv
design/cdas_alu.sv
design/cdas_year.sv
design/calendar_datetime_add_subtract.sv
design/cdas_chk.sv
tb/tb.sv
